// ----- src/fela_pkg.sv -----
// Shared types and constants of the fixed entry free list allocator.
package fela_pkg;

  // Field widths fixed by the interface.
  localparam int CNT_W      = 9;
  localparam int SIZE_W     = 16;
  localparam int ADDR_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // The quotient of a free never reaches the largest entry count, so it has CNT_W bits.
  localparam int Q_W        = CNT_W;
  localparam int PROD_W     = CNT_W + SIZE_W;
  localparam int DIV_CNT_W  = $clog2(Q_W);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTRIES_IN_USE = 2'd0,
    CFG_ENTRY_SIZE     = 2'd1,
    CFG_REGION_BASE    = 2'd2
  } cfg_reg_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_t;

  // Request kinds.
  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_CHECK,
    S_DIV,
    S_FREE_WR,
    S_RESP
  } state_t;

  // Register values after reset.
  localparam logic [CNT_W-1:0]  RST_ENTRIES_IN_USE = 9'd256;
  localparam logic [SIZE_W-1:0] RST_ENTRY_SIZE     = 16'd16;
  localparam logic [ADDR_W-1:0] RST_REGION_BASE    = 32'd0;

  // Last step of the restoring divider.
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(Q_W - 1);

endpackage

// ----- src/fela_ifs.sv -----
// Request, response and configuration channel interfaces of the allocator.
interface fela_req_if;
  import fela_pkg::*;
  logic               valid;
  logic               ready;
  req_type_t          req_type;
  logic [ADDR_W-1:0]  freed_address;
  modport source (output valid, output req_type, output freed_address, input ready);
  modport sink   (input valid, input req_type, input freed_address, output ready);
endinterface

interface fela_rsp_if;
  import fela_pkg::*;
  logic               valid;
  logic               ready;
  status_t            status;
  logic [ADDR_W-1:0]  granted_address;
  logic [CNT_W-1:0]   entries_allocated;
  modport source (output valid, output status, output granted_address,
                  output entries_allocated, input ready);
  modport sink   (input valid, input status, input granted_address,
                  input entries_allocated, output ready);
endinterface

interface fela_cfg_if;
  import fela_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/fixed_entry_free_list_allocator_unit.sv -----
// Fixed entry free list allocator: link memory, sequencer, divider and response register.
// Sequence: an allocate or a refused free passes through the calc, check and response states;
// an accepted free also runs the bit-serial divider and the link write before the response.
// A result waits in the response state while the response register is still full.
// Throughput: one request at a time; the next is taken when the sequencer is back in idle.
// Reset (synchronous, active low) holds ready low, clears the list head, watermark and count
// and loads the register defaults; the link memory is not cleared and needs no clearing pass.
module fixed_entry_free_list_allocator_unit #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  fela_req_if.sink    in_req,
  fela_rsp_if.source  out_rsp,
  fela_cfg_if.sink    cfg_wr
);
  import fela_pkg::*;

  // The entry count register has CNT_W bits, so indexes never exceed its largest value.
  localparam int LINK_DEPTH = (MAX_ENTRIES > (1 << CNT_W)) ? (1 << CNT_W) : MAX_ENTRIES;
  localparam int LINK_AW    = $clog2(LINK_DEPTH);
  localparam int CAP        = (MAX_ENTRIES > (1 << CNT_W) - 1) ? (1 << CNT_W) - 1
                                                                : MAX_ENTRIES;
  localparam logic [CNT_W-1:0] CAP_N = CNT_W'(CAP);

  // Configuration registers.
  logic [CNT_W-1:0]   entries_in_use_r;
  logic [SIZE_W-1:0]  entry_size_r;
  logic [ADDR_W-1:0]  region_base_r;

  // List state.
  logic [CNT_W-1:0]   free_head_r;
  logic [CNT_W-1:0]   clean_mark_r;
  logic [CNT_W-1:0]   alloc_count_r;

  // Sequencer and request registers.
  state_t             state_r, state_nxt;
  req_type_t          req_type_r;
  logic [ADDR_W-1:0]  freed_address_r;
  logic [CNT_W-1:0]   link_rd_r;
  logic [PROD_W-1:0]  grant_prod_r;
  logic [PROD_W-1:0]  region_bytes_r;
  logic [ADDR_W-1:0]  offset_r;
  logic [SIZE_W-1:0]  rem_r;
  logic [Q_W-1:0]     quot_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  status_t            res_status_r;
  logic [ADDR_W-1:0]  res_granted_r;

  // Response register.
  logic               out_valid_r;
  status_t            out_status_r;
  logic [ADDR_W-1:0]  out_granted_r;
  logic [CNT_W-1:0]   out_count_r;

  // Link memory.
  logic [CNT_W-1:0]   link_mem [LINK_DEPTH];

  logic               in_fire;
  logic               cfg_fire;
  logic               in_ready;
  logic               link_we;
  logic               out_load;
  logic [CNT_W-1:0]   n_eff;
  logic               alloc_refused;
  logic               free_outside;
  logic [SIZE_W:0]    div_trial;
  logic               div_ge;

  // Effective entry count is capped by the capacity.
  assign n_eff = (entries_in_use_r > CAP_N) ? CAP_N : entries_in_use_r;

  assign in_fire  = in_req.valid && in_ready;
  assign cfg_fire = cfg_wr.valid;

  assign alloc_refused = (alloc_count_r >= n_eff) || (free_head_r >= n_eff);
  assign free_outside  = (region_bytes_r == '0) ||
                         (offset_r >= {{(ADDR_W-PROD_W){1'b0}}, region_bytes_r});

  // One restoring division step: bring in the next offset bit and try a subtract.
  assign div_trial = {rem_r, quot_r[Q_W-1]};
  assign div_ge    = div_trial >= {1'b0, entry_size_r};

  // Sequencer: next state and control strobes.
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    link_we   = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = rst_n;
        if (in_req.valid) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (req_type_r == REQ_FREE && !free_outside) begin
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_DIV: begin
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = S_FREE_WR;
        end
      end
      S_FREE_WR: begin
        link_we   = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_in_use_r <= RST_ENTRIES_IN_USE;
      entry_size_r     <= RST_ENTRY_SIZE;
      region_base_r    <= RST_REGION_BASE;
    end else if (cfg_fire) begin
      unique case (cfg_reg_t'(cfg_wr.index))
        CFG_ENTRIES_IN_USE: entries_in_use_r <= cfg_wr.data[CNT_W-1:0];
        CFG_ENTRY_SIZE:     entry_size_r     <= cfg_wr.data[SIZE_W-1:0];
        CFG_REGION_BASE:    region_base_r    <= cfg_wr.data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Link memory: written on a free, read at the list head when a request is taken.
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[quot_r[LINK_AW-1:0]] <= free_head_r;
    end
    if (in_fire) begin
      link_rd_r <= link_mem[free_head_r[LINK_AW-1:0]];
    end
  end

  // List head, watermark and allocation count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r   <= '0;
      clean_mark_r  <= '0;
      alloc_count_r <= '0;
    end else if (state_r == S_CHECK && req_type_r == REQ_ALLOC && !alloc_refused) begin
      if (free_head_r == clean_mark_r) begin
        free_head_r  <= free_head_r + 1'b1;
        clean_mark_r <= clean_mark_r + 1'b1;
      end else begin
        free_head_r  <= link_rd_r;
      end
      alloc_count_r <= alloc_count_r + 1'b1;
    end else if (state_r == S_FREE_WR) begin
      free_head_r <= quot_r;
      if (alloc_count_r != '0) begin
        alloc_count_r <= alloc_count_r - 1'b1;
      end
    end
  end

  // Request datapath: products, offset, divider and result.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_type_r      <= in_req.req_type;
      freed_address_r <= in_req.freed_address;
    end
    if (state_r == S_CALC) begin
      grant_prod_r   <= {{SIZE_W{1'b0}}, free_head_r} * {{CNT_W{1'b0}}, entry_size_r};
      region_bytes_r <= {{SIZE_W{1'b0}}, n_eff} * {{CNT_W{1'b0}}, entry_size_r};
      offset_r       <= freed_address_r - region_base_r;
    end
    if (state_r == S_CHECK) begin
      if (req_type_r == REQ_ALLOC) begin
        if (alloc_refused) begin
          res_status_r  <= STATUS_FULL;
          res_granted_r <= '0;
        end else begin
          res_status_r  <= STATUS_DONE;
          res_granted_r <= region_base_r + {{(ADDR_W-PROD_W){1'b0}}, grant_prod_r};
        end
      end else if (free_outside) begin
        res_status_r  <= STATUS_RANGE;
        res_granted_r <= '0;
      end else begin
        // The offset is below count times size, so its upper part is below the size.
        res_status_r  <= STATUS_DONE;
        res_granted_r <= '0;
        rem_r         <= offset_r[Q_W+SIZE_W-1:Q_W];
        quot_r        <= offset_r[Q_W-1:0];
        div_cnt_r     <= '0;
      end
    end
    if (state_r == S_DIV) begin
      rem_r     <= div_ge ? SIZE_W'(div_trial - {1'b0, entry_size_r}) : div_trial[SIZE_W-1:0];
      quot_r    <= {quot_r[Q_W-2:0], div_ge};
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  // Response register: holds a finished result until it is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r  <= res_status_r;
      out_granted_r <= res_granted_r;
      out_count_r   <= alloc_count_r;
    end
  end

  assign in_req.ready              = in_ready;
  assign cfg_wr.ready              = rst_n;
  assign out_rsp.valid             = out_valid_r;
  assign out_rsp.status            = out_status_r;
  assign out_rsp.granted_address   = out_granted_r;
  assign out_rsp.entries_allocated = out_count_r;

  // The divider leaves a proper remainder and a quotient that rebuilds the offset.
  a_div_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FREE_WR |->
      rem_r < entry_size_r &&
      (ADDR_W'(quot_r) * ADDR_W'(entry_size_r) + ADDR_W'(rem_r)) == offset_r)
    else $error("divider result does not rebuild the offset");

  // A refused request reports no granted address.
  a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != STATUS_DONE |-> out_granted_r == '0)
    else $error("granted address set on a refused request");

  // The allocation count does not move while the sequencer is idle.
  a_count_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |=> $stable(alloc_count_r))
    else $error("allocation count changed while idle");

  // An accepted request starts the sequencer in the calc state.
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == S_CALC)
    else $error("accepted request did not start the sequencer");

endmodule

// ----- tb/fixed_entry_free_list_allocator_unit_test.sv -----
// Self-checking testbench for the fixed entry free list allocator unit.
module fixed_entry_free_list_allocator_unit_test;
  import fela_pkg::*;

  localparam int POOL_DEPTH     = 256;
  localparam int HOLD_AT        = 60;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 30;

  typedef struct {
    req_type_t         kind;
    logic [ADDR_W-1:0] addr;
  } alloc_request_t;

  typedef struct {
    status_t           status;
    logic [ADDR_W-1:0] addr;
    logic [CNT_W-1:0]  count;
  } alloc_result_t;

  logic clk;
  logic rst_n;

  fela_req_if in_bus();
  fela_rsp_if out_bus();
  fela_cfg_if cfg_bus();

  fixed_entry_free_list_allocator_unit #(
    .MAX_ENTRIES(POOL_DEPTH)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_bus),
    .out_rsp(out_bus),
    .cfg_wr (cfg_bus)
  );

  // Shadow copy of the allocator state and its registers.
  logic [CNT_W-1:0]  chain_ram [POOL_DEPTH];
  logic [CNT_W-1:0]  chain_top;
  logic [CNT_W-1:0]  fresh_edge;
  logic [CNT_W-1:0]  slots_in_use;
  logic [CNT_W-1:0]  cfg_count;
  logic [SIZE_W-1:0] cfg_size;
  logic [ADDR_W-1:0] cfg_base;

  alloc_request_t pending_reqs[$];
  alloc_result_t  expected_results[$];
  int             granted_slots[$];
  alloc_request_t in_flight_req;

  bit sender_idles;
  bit receiver_idles;
  int send_gap;
  int sink_stall;
  int sink_hold;
  int quiet_cycles;
  bit took_request;

  int mismatch_count;
  int results_seen;
  int alloc_reqs;
  int free_reqs;
  int full_refusals;
  int range_refusals;
  int cfg_writes;
  int settings_used;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_wait(bit enabled);
    return enabled ? $urandom_range(0, 13) : 0;
  endfunction

  // Entry count in force: anything above the pool depth acts as the pool depth.
  function automatic logic [CNT_W-1:0] live_entries();
    return (cfg_count > POOL_DEPTH) ? CNT_W'(POOL_DEPTH) : cfg_count;
  endfunction

  function automatic logic [PROD_W-1:0] region_span();
    return {{SIZE_W{1'b0}}, live_entries()} * {{CNT_W{1'b0}}, cfg_size};
  endfunction

  // Applies one accepted request to the shadow state and returns its response.
  function automatic alloc_result_t serve_request(alloc_request_t r);
    alloc_result_t     res;
    logic [CNT_W-1:0]  n;
    logic [PROD_W-1:0] span;
    logic [ADDR_W-1:0] offset;
    logic [ADDR_W-1:0] slot;
    n = live_entries();
    span = region_span();
    res.status = STATUS_DONE;
    res.addr = '0;
    if (r.kind == REQ_ALLOC) begin
      alloc_reqs++;
      if (slots_in_use >= n || chain_top >= n) begin
        res.status = STATUS_FULL;
        full_refusals++;
      end else begin
        res.addr = cfg_base + ADDR_W'(chain_top) * ADDR_W'(cfg_size);
        granted_slots.push_back(int'(chain_top));
        // A head at the watermark hands out a clean entry; otherwise pop the list.
        if (chain_top == fresh_edge) begin
          chain_top = chain_top + 1'b1;
          fresh_edge = fresh_edge + 1'b1;
        end else begin
          chain_top = chain_ram[chain_top[7:0]];
        end
        slots_in_use = slots_in_use + 1'b1;
      end
    end else begin
      free_reqs++;
      offset = r.addr - cfg_base;
      if (span == '0 || offset >= ADDR_W'(span)) begin
        res.status = STATUS_RANGE;
        range_refusals++;
      end else begin
        slot = offset / ADDR_W'(cfg_size);
        chain_ram[slot[7:0]] = chain_top;
        chain_top = slot[CNT_W-1:0];
        if (slots_in_use != '0) slots_in_use = slots_in_use - 1'b1;
      end
    end
    res.count = slots_in_use;
    return res;
  endfunction

  // Byte address of a slot in the current region, optionally somewhere inside the entry.
  function automatic logic [ADDR_W-1:0] slot_address(int slot, bit unaligned);
    logic [ADDR_W-1:0] a;
    a = cfg_base + ADDR_W'(slot) * ADDR_W'(cfg_size);
    if (unaligned && cfg_size != '0) a = a + ADDR_W'($urandom_range(0, cfg_size - 1));
    return a;
  endfunction

  // An address that lies outside the current region, often right at its edges.
  function automatic logic [ADDR_W-1:0] stray_address();
    logic [ADDR_W-1:0] a;
    logic [PROD_W-1:0] span;
    span = region_span();
    do begin
      case ($urandom_range(0, 3))
        0: a = cfg_base - 32'd1;
        1: a = cfg_base + ADDR_W'(span);
        default: a = $urandom();
      endcase
    end while (span != '0 && (a - cfg_base) < ADDR_W'(span));
    return a;
  endfunction

  // Keep the request queue short so that frees follow the grants closely.
  task automatic queue_request(req_type_t kind, logic [ADDR_W-1:0] addr);
    alloc_request_t r;
    while (pending_reqs.size() >= 2) @(posedge clk);
    r.kind = kind;
    r.addr = addr;
    pending_reqs.push_back(r);
  endtask

  task automatic queue_alloc();
    queue_request(REQ_ALLOC, $urandom());
  endtask

  task automatic queue_free(logic [ADDR_W-1:0] addr);
    queue_request(REQ_FREE, addr);
  endtask

  // Waits until every request has been sent and answered; sampled between edges so that
  // the driver's updates of the same edge are already visible.
  task automatic settle();
    while (pending_reqs.size() != 0 || in_bus.valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Frees a granted slot chosen by its position in the list of outstanding grants.
  task automatic release_held(int pos, bit unaligned);
    int slot;
    settle();
    slot = granted_slots[pos];
    granted_slots.delete(pos);
    queue_free(slot_address(slot, unaligned));
  endtask

  // Writes all three registers; valid stays high across back-to-back writes.
  task automatic load_settings(logic [CNT_W-1:0] entries, logic [SIZE_W-1:0] size,
                               logic [ADDR_W-1:0] base);
    cfg_reg_t          which [3];
    logic [ADDR_W-1:0] vals [3];
    which = '{CFG_ENTRIES_IN_USE, CFG_ENTRY_SIZE, CFG_REGION_BASE};
    vals = '{ADDR_W'(entries), ADDR_W'(size), base};
    settle();
    for (int i = 0; i < 3; i++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= which[i];
      cfg_bus.data <= vals[i];
      @(posedge clk);
      while (!cfg_bus.ready) @(posedge clk);
      case (which[i])
        CFG_ENTRIES_IN_USE: cfg_count = vals[i][CNT_W-1:0];
        CFG_ENTRY_SIZE:     cfg_size = vals[i][SIZE_W-1:0];
        default:            cfg_base = vals[i];
      endcase
      cfg_writes++;
    end
    cfg_bus.valid <= 1'b0;
    settings_used++;
  endtask

  // One random request: mostly grants and frees of held slots, some strays.
  task automatic random_request(int alloc_pct, int cap);
    int pick;
    int slot;
    if ($urandom_range(0, 99) < 8) begin
      queue_free(stray_address());
    end else if (granted_slots.size() == 0 ||
                 ($urandom_range(0, 99) < alloc_pct && granted_slots.size() < cap)) begin
      queue_alloc();
    end else begin
      pick = $urandom_range(0, granted_slots.size() - 1);
      slot = granted_slots[pick];
      // A slot beyond the current region stays held; its free is refused.
      if (slot < live_entries() && cfg_size != '0) granted_slots.delete(pick);
      queue_free(slot_address(slot, $urandom_range(0, 3) == 0));
    end
  endtask

  // Returns every held slot that the region still covers, highest index first.
  task automatic drain_slots();
    int order[$];
    settle();
    order = granted_slots;
    order.rsort();
    granted_slots = {};
    foreach (order[i]) begin
      if (order[i] < live_entries() && cfg_size != '0) queue_free(slot_address(order[i], 0));
      else granted_slots.push_back(order[i]);
    end
  endtask

  task automatic run_phase(logic [CNT_W-1:0] entries, logic [SIZE_W-1:0] size,
                           logic [ADDR_W-1:0] base, int items, int alloc_pct, int cap,
                           bit idles);
    load_settings(entries, size, base);
    sender_idles = idles;
    receiver_idles = idles;
    repeat (items) random_request(alloc_pct, cap);
    drain_slots();
  endtask

  // Request driver: one request per handshake, with a drawn gap before the next.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_bus.req_type <= REQ_ALLOC;
      in_bus.freed_address <= '0;
      send_gap = 0;
    end else begin
      took_request = in_bus.valid && in_bus.ready;
      if (took_request) begin
        expected_results.push_back(serve_request(in_flight_req));
        send_gap = draw_wait(sender_idles);
      end
      if (!in_bus.valid || took_request) begin
        if (send_gap > 0) begin
          send_gap--;
          in_bus.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          in_flight_req = pending_reqs.pop_front();
          in_bus.valid <= 1'b1;
          in_bus.req_type <= in_flight_req.kind;
          in_bus.freed_address <= in_flight_req.addr;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: checks each response and draws the stall before the next.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      sink_stall = 0;
      sink_hold = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: response with none expected, status %0d addr %h count %0d",
                   $time, out_bus.status, out_bus.granted_address, out_bus.entries_allocated);
          mismatch_count++;
        end else begin
          alloc_result_t want;
          want = expected_results.pop_front();
          if (out_bus.status !== want.status) begin
            $display("%0t: status expected %0d, got %0d", $time, want.status, out_bus.status);
            mismatch_count++;
          end
          if (out_bus.granted_address !== want.addr) begin
            $display("%0t: granted address expected %h, got %h",
                     $time, want.addr, out_bus.granted_address);
            mismatch_count++;
          end
          if (out_bus.entries_allocated !== want.count) begin
            $display("%0t: entries allocated expected %0d, got %0d",
                     $time, want.count, out_bus.entries_allocated);
            mismatch_count++;
          end
        end
        results_seen++;
        sink_stall = draw_wait(receiver_idles);
        // One long hold-off so that the block backs up and stalls its input.
        if (results_seen == HOLD_AT) sink_hold = HOLD_CYCLES;
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_bus.ready <= 1'b0;
      end else if (sink_stall > 0) begin
        sink_stall--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: directed corner cases, random phases over several settings, then a double free.
  initial begin
    int slot;
    rst_n <= 1'b0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= CFG_ENTRIES_IN_USE;
    cfg_bus.data <= '0;
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    for (int i = 0; i < POOL_DEPTH; i++) chain_ram[i] = '0;
    chain_top = '0;
    fresh_edge = '0;
    slots_in_use = '0;
    cfg_count = RST_ENTRIES_IN_USE;
    cfg_size = RST_ENTRY_SIZE;
    cfg_base = RST_REGION_BASE;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: free into an empty pool, grants, an unaligned free, both region edges.
    queue_free(32'h0000_0FFF);
    repeat (4) queue_alloc();
    release_held(2, 1'b1);
    queue_alloc();
    queue_free(32'h0000_1000);
    queue_free(32'hFFFF_FFFF);
    release_held(0, 1'b0);

    // Empty region: no entries at all.
    load_settings(9'd0, 16'd16, 32'h0000_1000);
    queue_alloc();
    queue_free(32'h0000_1000);
    queue_free(32'h0000_0000);

    // Zero entry size.
    load_settings(9'd8, 16'd0, 32'h0000_2000);
    queue_alloc();
    queue_free(32'h0000_2000);

    // Oversized entry count, largest entries, region wrapping past the top of memory.
    load_settings(9'd511, 16'hFFFF, 32'hFFFF_FFFF);
    queue_alloc();
    queue_alloc();
    queue_free(32'hFFFF_FFFE);
    settle();
    release_held(granted_slots.size() - 1, 1'b1);

    // Single small entry at the very top of memory.
    load_settings(9'd1, 16'd4, 32'hFFFF_FFFC);
    queue_alloc();
    queue_alloc();
    queue_free(32'h0000_0000);

    run_phase(9'd256, 16'd16, 32'h0000_0000, 100, 50, 40, 1'b1);
    run_phase(9'd12, 16'd4, 32'h8000_0000, 80, 55, 16, 1'b0);
    run_phase(9'd256, 16'hFFFF, 32'hFFF0_0000, 110, 70, 200, 1'b1);
    run_phase(9'd1, 16'd4, 32'hFFFF_FFFC, 30, 50, 3, 1'b1);
    run_phase(9'd64, 16'd24, $urandom(), 110, 45, 70, 1'b0);
    run_phase(9'd300, 16'($urandom_range(4, 65535)), $urandom(), 100, 60, 40, 1'b1);
    run_phase(9'd200, 16'd4, 32'h0000_0000, 90, 30, 210, 1'b1);

    // Double free of one entry, then grants from the looped list.
    queue_alloc();
    settle();
    slot = granted_slots[$];
    granted_slots.pop_back();
    queue_free(slot_address(slot, 1'b0));
    queue_free(slot_address(slot, 1'b1));
    repeat (3) queue_alloc();

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d allocate and %0d free requests: %0d refused as full, %0d frees outside.",
             alloc_reqs, free_reqs, full_refusals, range_refusals);
    $display("%0d register writes over %0d region settings, %0d responses checked.",
             cfg_writes, settings_used, results_seen);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
